>>> sv/vmalu_pkg.sv
// ----------------------------------------------------------------------------
// vmalu_pkg
// shared constants, opcodes, error codes and link types of the vm alu
// ----------------------------------------------------------------------------
package vmalu_pkg;

    localparam int WORD_W = 32;
    localparam int ACT_W  = 5;
    localparam int ERR_W  = 3;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [ACT_W-1:0] ACT_ADD  = 5'd0;
    localparam logic [ACT_W-1:0] ACT_SUB  = 5'd1;
    localparam logic [ACT_W-1:0] ACT_INC  = 5'd2;
    localparam logic [ACT_W-1:0] ACT_DEC  = 5'd3;
    localparam logic [ACT_W-1:0] ACT_MUL  = 5'd4;
    localparam logic [ACT_W-1:0] ACT_DIV  = 5'd5;
    localparam logic [ACT_W-1:0] ACT_MOD  = 5'd6;
    localparam logic [ACT_W-1:0] ACT_AND  = 5'd7;
    localparam logic [ACT_W-1:0] ACT_NAND = 5'd8;
    localparam logic [ACT_W-1:0] ACT_NOR  = 5'd9;
    localparam logic [ACT_W-1:0] ACT_OR   = 5'd10;
    localparam logic [ACT_W-1:0] ACT_XOR  = 5'd11;
    localparam logic [ACT_W-1:0] ACT_NOT  = 5'd12;
    localparam logic [ACT_W-1:0] ACT_CMP  = 5'd13;
    localparam logic [ACT_W-1:0] ACT_SHL  = 5'd14;
    localparam logic [ACT_W-1:0] ACT_SHR  = 5'd15;
    localparam logic [ACT_W-1:0] ACT_SAR  = 5'd16;
    localparam logic [ACT_W-1:0] ACT_SLTU = 5'd17;

    localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
    localparam logic [ERR_W-1:0] ERR_ADD   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_MUL   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DIV   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_SHIFT = 3'd4;

    typedef struct packed {
        logic start;
        logic is_mul;
    } iter_ctl_t;

    typedef struct packed {
        logic done;
        logic mul_ovf;
    } iter_stat_t;

endpackage

>>> sv/vmalu_iter.sv
// ----------------------------------------------------------------------------
// vmalu_iter
// shared 33-bit add/subtract unit stepped one bit per cycle: shift-add
// multiply or restoring divide, stepping only in its active cycles
// ----------------------------------------------------------------------------
module vmalu_iter
    import vmalu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  iter_ctl_t         ctl,
    input  logic [WORD_W-1:0] operand_a,
    input  logic [WORD_W-1:0] operand_b,
    output iter_stat_t        stat,
    output logic [WORD_W-1:0] low_word,
    output logic [WORD_W-1:0] high_word
);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic              is_mul_reg, is_mul_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [WORD_W-1:0] b_reg, b_next;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   add_x;
    logic [WORD_W:0]   add_y;
    logic              add_cin;
    logic [WORD_W+1:0] add_sum;
    logic              ge;

    assign shifted = {acc_reg, lo_reg[WORD_W-1]};

    always_comb
    begin
        if (is_mul_reg)
        begin
            add_x   = {1'b0, acc_reg};
            add_y   = lo_reg[0] ? {1'b0, b_reg} : '0;
            add_cin = 1'b0;
        end
        else
        begin
            add_x   = shifted;
            add_y   = ~{1'b0, b_reg};
            add_cin = 1'b1;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + (WORD_W+2)'(add_cin);
        ge      = add_sum[WORD_W+1];
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        is_mul_next = is_mul_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        lo_next     = lo_reg;
        b_next      = b_reg;
        if (ctl.start)
        begin
            active_next = 1'b1;
            is_mul_next = ctl.is_mul;
            cnt_next    = '0;
            acc_next    = '0;
            lo_next     = operand_a;
            b_next      = operand_b;
        end
        else if (active_reg)
        begin
            if (is_mul_reg)
            begin
                acc_next = add_sum[WORD_W:1];
                lo_next  = {add_sum[0], lo_reg[WORD_W-1:1]};
            end
            else
            begin
                acc_next = ge ? add_sum[WORD_W-1:0] : shifted[WORD_W-1:0];
                lo_next  = {lo_reg[WORD_W-2:0], ge};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W-1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            is_mul_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            is_mul_reg <= is_mul_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
        b_reg   <= b_next;
    end

    assign stat.done    = done_reg;
    assign stat.mul_ovf = (acc_reg != '0);
    assign low_word     = lo_reg;
    assign high_word    = acc_reg;

endmodule

>>> sv/vm_alu_with_flags.sv
// ----------------------------------------------------------------------------
// vm_alu_with_flags
// 32-bit vm alu with stored zero and negative flags and error codes
// ----------------------------------------------------------------------------
// done and result are registered from the exec state for single-pass
//   operations; mul, div and mod start the iterative unit there (one bit per
//   cycle in the shared add/subtract unit) and finish from the iter state
// no new transfer is taken while busy, which also holds for mul, div and mod
// busy is high from the start transfer until done; the receiver cannot stall
// reset clears the flags, the sequencer and the done strobe
// ----------------------------------------------------------------------------
module vm_alu_with_flags
    import vmalu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  action,
    input  logic [WORD_W-1:0] operand_a,
    input  logic [WORD_W-1:0] operand_b,
    output logic              done,
    output logic [WORD_W-1:0] result,
    output logic              zero_flag,
    output logic              negative_flag,
    output logic [ERR_W-1:0]  error_code
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_ITER = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ACT_W-1:0]  act_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic              flag_zero_reg, flag_zero_next;
    logic              flag_negative_reg, flag_negative_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] result_reg, result_next;
    logic [ERR_W-1:0]  error_reg, error_next;

    iter_ctl_t         iter_ctl;
    iter_stat_t        iter_stat;
    logic [WORD_W-1:0] iter_low;
    logic [WORD_W-1:0] iter_high;

    logic [WORD_W:0]   add_sum;
    logic [WORD_W-1:0] sub_rhs;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] abs_diff;
    logic              shift_big;
    logic [WORD_W-1:0] shift_val;

    logic              fin;
    logic              fin_upd;
    logic              fin_neg_lt;
    logic              fin_lt;
    logic [WORD_W-1:0] fin_result;
    logic [ERR_W-1:0]  fin_err;

    vmalu_iter u_iter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (iter_ctl),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .stat      (iter_stat),
        .low_word  (iter_low),
        .high_word (iter_high)
    );

    always_comb
    begin
        add_sum   = {1'b0, a_reg} + ((act_reg == ACT_INC) ? (WORD_W+1)'(1) : {1'b0, b_reg});
        sub_rhs   = (act_reg == ACT_DEC) ? WORD_W'(1) : b_reg;
        diff      = {1'b0, a_reg} - {1'b0, sub_rhs};
        abs_diff  = diff[WORD_W] ? (~diff[WORD_W-1:0] + WORD_W'(1)) : diff[WORD_W-1:0];
        shift_big = (b_reg[WORD_W-1:CNT_W] != '0);
        unique case (act_reg)
            ACT_SHL: shift_val = a_reg << b_reg[CNT_W-1:0];
            ACT_SAR: shift_val = WORD_W'($signed(a_reg) >>> b_reg[CNT_W-1:0]);
            default: shift_val = a_reg >> b_reg[CNT_W-1:0];
        endcase
    end

    always_comb
    begin
        fin        = 1'b0;
        fin_upd    = 1'b0;
        fin_neg_lt = 1'b0;
        fin_lt     = 1'b0;
        fin_result = '0;
        fin_err    = ERR_NONE;
        iter_ctl   = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                fin        = 1'b1;
                state_next = ST_IDLE;
                unique case (act_reg) inside
                    ACT_ADD, ACT_INC:
                    begin
                        if (add_sum[WORD_W])
                        begin
                            fin_err = ERR_ADD;
                        end
                        else
                        begin
                            fin_result = add_sum[WORD_W-1:0];
                            fin_upd    = 1'b1;
                        end
                    end
                    ACT_SUB, ACT_DEC:
                    begin
                        fin_result = abs_diff;
                        fin_upd    = 1'b1;
                        fin_neg_lt = 1'b1;
                        fin_lt     = diff[WORD_W];
                    end
                    ACT_MUL, ACT_DIV, ACT_MOD:
                    begin
                        if (act_reg != ACT_MUL && b_reg == '0)
                        begin
                            fin_err = ERR_DIV;
                        end
                        else
                        begin
                            fin             = 1'b0;
                            iter_ctl.start  = 1'b1;
                            iter_ctl.is_mul = (act_reg == ACT_MUL);
                            state_next      = ST_ITER;
                        end
                    end
                    ACT_AND:  begin fin_result = a_reg & b_reg;     fin_upd = 1'b1; end
                    ACT_NAND: begin fin_result = ~(a_reg & b_reg);  fin_upd = 1'b1; end
                    ACT_NOR:  begin fin_result = ~(a_reg | b_reg);  fin_upd = 1'b1; end
                    ACT_OR:   begin fin_result = a_reg | b_reg;     fin_upd = 1'b1; end
                    ACT_XOR:  begin fin_result = a_reg ^ b_reg;     fin_upd = 1'b1; end
                    ACT_NOT:  begin fin_result = ~a_reg;            fin_upd = 1'b1; end
                    ACT_CMP:  begin fin_result = diff[WORD_W-1:0];  fin_upd = 1'b1; end
                    ACT_SLTU:
                    begin
                        fin_result = WORD_W'(diff[WORD_W]);
                        fin_upd    = 1'b1;
                    end
                    ACT_SHL, ACT_SHR, ACT_SAR:
                    begin
                        if (shift_big)
                        begin
                            fin_err = ERR_SHIFT;
                        end
                        else if (b_reg == '0)
                        begin
                            fin_result = a_reg;
                        end
                        else
                        begin
                            fin_result = shift_val;
                            fin_upd    = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin_result = '0;
                    end
                endcase
            end
            ST_ITER:
            begin
                if (iter_stat.done)
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                    if (act_reg == ACT_MUL)
                    begin
                        if (iter_stat.mul_ovf)
                        begin
                            fin_err = ERR_MUL;
                        end
                        else
                        begin
                            fin_result = iter_low;
                            fin_upd    = 1'b1;
                        end
                    end
                    else
                    begin
                        fin_result = (act_reg == ACT_DIV) ? iter_low : iter_high;
                        fin_upd    = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        flag_zero_next     = flag_zero_reg;
        flag_negative_next = flag_negative_reg;
        done_next          = fin;
        result_next        = result_reg;
        error_next         = error_reg;
        if (fin)
        begin
            result_next = fin_result;
            error_next  = fin_err;
            if (fin_upd)
            begin
                flag_zero_next     = (fin_result == '0);
                flag_negative_next = fin_neg_lt ? fin_lt : fin_result[WORD_W-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            flag_zero_reg     <= 1'b0;
            flag_negative_reg <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            flag_zero_reg     <= flag_zero_next;
            flag_negative_reg <= flag_negative_next;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            act_reg <= action;
            a_reg   <= operand_a;
            b_reg   <= operand_b;
        end
        result_reg <= result_next;
        error_reg  <= error_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign result        = result_reg;
    assign zero_flag     = flag_zero_reg;
    assign negative_flag = flag_negative_reg;
    assign error_code    = error_reg;

`ifndef SYNTHESIS
    a_err_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && error_code != ERR_NONE |-> result == '0)
        else $error("error result not zero");

    a_err_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done && error_code != ERR_NONE |-> $stable({zero_flag, negative_flag}))
        else $error("flags changed on error");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("transfer did not enter busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_iter_single: assert property (@(posedge clk) disable iff (!rst_n)
        iter_stat.done |-> state_reg == ST_ITER)
        else $error("iterative unit finished outside its phase");
`endif

endmodule

>>> test/vm_alu_with_flags_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm_alu_with_flags_test
// self-checking bench for the vm alu: a scoreboard keeps its own copy of the
// zero and negative flags, predicts every result, error code and flag pair,
// and checks each done strobe against the oldest prediction; directed corner
// cases come first, then random traffic under three sender idle profiles
// ----------------------------------------------------------------------------
module vm_alu_with_flags_test;
    import vmalu_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 670;

    typedef struct packed {
        logic [WORD_W-1:0] res;
        logic              z;
        logic              n;
        logic [ERR_W-1:0]  err;
    } alu_out_t;

    class alu_flag_book;
        logic       zf;
        logic       nf;
        alu_out_t   pending_q[$];
        int unsigned errors;

        function new();
            zf = 1'b0;
            nf = 1'b0;
            errors = 0;
        endfunction

        function void load_flags(logic [WORD_W-1:0] v);
            zf = (v == '0);
            nf = v[WORD_W-1];
        endfunction

        function logic [WORD_W-1:0] abs_diff(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
            logic [WORD_W-1:0] r;
            if (a >= b)
            begin
                r = a - b;
                nf = 1'b0;
            end
            else
            begin
                r = b - a;
                nf = 1'b1;
            end
            zf = (r == '0);
            return r;
        endfunction

        function void note_transfer(logic [ACT_W-1:0] act, logic [WORD_W-1:0] a,
                                    logic [WORD_W-1:0] b);
            alu_out_t          o;
            logic [WORD_W:0]   sum;
            logic [2*WORD_W-1:0] prod;
            o.res = '0;
            o.err = ERR_NONE;
            case (act) inside
                ACT_ADD, ACT_INC:
                begin
                    sum = {1'b0, a} + ((act == ACT_INC) ? {{WORD_W{1'b0}}, 1'b1} : {1'b0, b});
                    if (sum[WORD_W])
                        o.err = ERR_ADD;
                    else
                    begin
                        o.res = sum[WORD_W-1:0];
                        load_flags(o.res);
                    end
                end
                ACT_SUB: o.res = abs_diff(a, b);
                ACT_DEC: o.res = abs_diff(a, 1);
                ACT_MUL:
                begin
                    prod = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
                    if (prod[2*WORD_W-1:WORD_W] != '0)
                        o.err = ERR_MUL;
                    else
                    begin
                        o.res = prod[WORD_W-1:0];
                        load_flags(o.res);
                    end
                end
                ACT_DIV, ACT_MOD:
                begin
                    if (b == '0)
                        o.err = ERR_DIV;
                    else
                    begin
                        o.res = (act == ACT_DIV) ? a / b : a % b;
                        load_flags(o.res);
                    end
                end
                ACT_AND:  begin o.res = a & b;    load_flags(o.res); end
                ACT_NAND: begin o.res = ~(a & b); load_flags(o.res); end
                ACT_NOR:  begin o.res = ~(a | b); load_flags(o.res); end
                ACT_OR:   begin o.res = a | b;    load_flags(o.res); end
                ACT_XOR:  begin o.res = a ^ b;    load_flags(o.res); end
                ACT_NOT:  begin o.res = ~a;       load_flags(o.res); end
                ACT_CMP:  begin o.res = a - b;    load_flags(o.res); end
                ACT_SHL, ACT_SHR, ACT_SAR:
                begin
                    if (b >= WORD_W)
                        o.err = ERR_SHIFT;
                    else if (b == '0)
                        o.res = a;
                    else
                    begin
                        if (act == ACT_SHL)
                            o.res = a << b[CNT_W-1:0];
                        else if (act == ACT_SHR)
                            o.res = a >> b[CNT_W-1:0];
                        else
                            o.res = $unsigned($signed(a) >>> b[CNT_W-1:0]);
                        load_flags(o.res);
                    end
                end
                ACT_SLTU: begin o.res = (a < b) ? 1 : 0; load_flags(o.res); end
                default: ;
            endcase
            o.z = zf;
            o.n = nf;
            pending_q.push_back(o);
        endfunction

        function void check_result(logic [WORD_W-1:0] r, logic z, logic n,
                                   logic [ERR_W-1:0] e);
            alu_out_t x;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: result %h err %0d", $time, r, e);
                errors++;
                return;
            end
            x = pending_q.pop_front();
            if (r !== x.res)
            begin
                $display("%0t: result expected %h actual %h", $time, x.res, r);
                errors++;
            end
            if (z !== x.z)
            begin
                $display("%0t: zero_flag expected %b actual %b", $time, x.z, z);
                errors++;
            end
            if (n !== x.n)
            begin
                $display("%0t: negative_flag expected %b actual %b", $time, x.n, n);
                errors++;
            end
            if (e !== x.err)
            begin
                $display("%0t: error_code expected %0d actual %0d", $time, x.err, e);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
    logic              done;
    logic [WORD_W-1:0] result;
    logic              zero_flag;
    logic              negative_flag;
    logic [ERR_W-1:0]  error_code;

    alu_flag_book book = new();
    int unsigned  stall_cycles = 0;

    vm_alu_with_flags dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .done          (done),
        .result        (result),
        .zero_flag     (zero_flag),
        .negative_flag (negative_flag),
        .error_code    (error_code)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                book.note_transfer(action, operand_a, operand_b);
            if (done)
                book.check_result(result, zero_flag, negative_flag, error_code);
        end
    end

    // watchdog on cycles with no transfer and no result
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("vm_alu_with_flags_test: done, errors");
            $finish;
        end
    end

    task automatic send_op(logic [ACT_W-1:0] act, logic [WORD_W-1:0] a,
                           logic [WORD_W-1:0] b, int unsigned idle_pct);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 40)) @(negedge clk);
            else
                repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        start     <= 1'b1;
        action    <= act;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return 32'h8000_0000;
            4: return $urandom_range(0, 255);
            5: return $urandom_range(0, 65535);
            6: return $urandom() >> $urandom_range(0, 31);
            7: return '1 - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(int unsigned idle_pct);
        logic [ACT_W-1:0]  act;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if ($urandom_range(99) < 5)
                act = ACT_W'($urandom_range(ACT_SLTU + 1, 31));
            else
                act = ACT_W'($urandom_range(ACT_ADD, ACT_SLTU));
            a = pick_word();
            b = pick_word();
            if ((act == ACT_SHL || act == ACT_SHR || act == ACT_SAR) && $urandom_range(9) < 8)
                b = $urandom_range(0, WORD_W - 1);
            send_op(act, a, b, idle_pct);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = ACT_ADD;
        operand_a    = '0;
        operand_b    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner cases
        send_op(ACT_ADD,  32'hffff_fffe, 32'h0000_0001, 0);
        send_op(ACT_ADD,  32'hffff_ffff, 32'h0000_0001, 0);
        send_op(ACT_INC,  32'hffff_ffff, 32'h1234_5678, 0);
        send_op(ACT_INC,  32'h0000_0000, 32'hffff_ffff, 0);
        send_op(ACT_SUB,  32'h0000_0003, 32'h0000_0007, 0);
        send_op(ACT_SUB,  32'hffff_ffff, 32'hffff_ffff, 0);
        send_op(ACT_DEC,  32'h0000_0000, 32'hffff_ffff, 0);
        send_op(ACT_DEC,  32'h0000_0001, 32'h0000_0000, 0);
        send_op(ACT_MUL,  32'h0001_0000, 32'h0001_0000, 0);
        send_op(ACT_MUL,  32'hffff_ffff, 32'h0000_0001, 0);
        send_op(ACT_DIV,  32'hffff_ffff, 32'h0000_0000, 0);
        send_op(ACT_DIV,  32'hffff_ffff, 32'h0000_0001, 0);
        send_op(ACT_MOD,  32'h8000_0000, 32'h0000_0000, 0);
        send_op(ACT_MOD,  32'hffff_ffff, 32'h0000_0007, 0);
        send_op(ACT_AND,  32'hf0f0_f0f0, 32'h0f0f_0f0f, 0);
        send_op(ACT_NAND, 32'h0000_0000, 32'hffff_ffff, 0);
        send_op(ACT_NOR,  32'h0000_0000, 32'h0000_0000, 0);
        send_op(ACT_OR,   32'h8000_0000, 32'h0000_0001, 0);
        send_op(ACT_XOR,  32'hffff_ffff, 32'hffff_ffff, 0);
        send_op(ACT_NOT,  32'h0000_0000, 32'h0000_0000, 0);
        send_op(ACT_CMP,  32'h0000_0000, 32'h0000_0001, 0);
        send_op(ACT_SHL,  32'h8000_0001, 32'h0000_0000, 0);
        send_op(ACT_SHL,  32'h0000_0001, 32'h0000_001f, 0);
        send_op(ACT_SHR,  32'hffff_ffff, 32'h0000_0020, 0);
        send_op(ACT_SAR,  32'h8000_0000, 32'h0000_001f, 0);
        send_op(ACT_SAR,  32'h7fff_ffff, 32'hffff_ffff, 0);
        send_op(ACT_SLTU, 32'hffff_fffe, 32'hffff_ffff, 0);
        send_op(5'd31,    32'hffff_ffff, 32'hffff_ffff, 0);

        random_phase(19);
        random_phase(65);
        random_phase(0);

        @(negedge clk);
        start <= 1'b0;
        while (book.pending_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (book.errors == 0)
            $display("vm_alu_with_flags_test: done, clean");
        else
            $display("vm_alu_with_flags_test: done, errors");
        $finish;
    end

endmodule
